>>> sv/ffd_pkg.sv
// Shared types, constants and helpers for the fractional feedback delay.
package ffd_pkg;

    localparam int S_W    = 24;
    localparam int GAIN_W = 17;
    localparam int MA_W   = 36;
    localparam int MB_W   = 25;
    localparam int MP_W   = MA_W + MB_W;

    // floor(2^24 / 6), used to divide weight terms by six
    localparam logic [MB_W-1:0] RECIP6   = 25'd2796202;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

    localparam logic signed [31:0] S24_MAX = 32'sd8388607;
    localparam logic signed [31:0] S24_MIN = -32'sd8388608;

    typedef logic signed [S_W-1:0] t_sample;

    typedef struct packed {
        logic [15:0]       frac;
        logic [GAIN_W-1:0] gain;
    } t_cfg;

    function automatic t_sample sat24(input logic signed [31:0] v);
        t_sample r;
        if (v > S24_MAX) begin
            r = S24_MAX[S_W-1:0];
        end else if (v < S24_MIN) begin
            r = S24_MIN[S_W-1:0];
        end else begin
            r = v[S_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/ffd_mul.sv
// Shared signed multiplier with registered product.
module ffd_mul import ffd_pkg::*; (
    input  logic                   i_clk,
    input  logic signed [MA_W-1:0] i_a,
    input  logic signed [MB_W-1:0] i_b,
    output logic signed [MP_W-1:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule

>>> sv/ffd_core.sv
// Sequencer, sample store and datapath of the interpolating feedback delay.
module ffd_core import ffd_pkg::*; #(
    parameter int BUFFER_DEPTH = 65536,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_sample       i_sample_in,
    input  logic [AW-1:0] i_dint,
    input  t_cfg          i_cfg,
    output logic          o_idle,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_sample       o_sample_out
);

    localparam logic [AW-1:0] LAST    = AW'(BUFFER_DEPTH - 1);
    localparam logic [AW+1:0] DEPTH_X = (AW+2)'(BUFFER_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_ADDR, S_W1, S_W2, S_W3, S_W4, S_W5, S_W6, S_W7,
        S_TAP, S_ACC, S_Y, S_FB, S_WB, S_DONE
    } t_state;

    t_state                 r_state;
    logic [AW-1:0]          r_wp;
    logic [AW-1:0]          r_raddr;
    logic [AW-1:0]          r_s1;
    logic                   r_full;
    logic                   r_rvalid;
    logic                   r_out_valid;
    t_sample                r_x;
    t_sample                r_y;
    t_sample                r_out;
    t_sample                r_rdata;
    t_sample                r_mem [BUFFER_DEPTH];
    logic signed [31:0]     r_a;
    logic signed [MA_W-1:0] r_c;
    logic signed [MA_W-1:0] r_e;
    logic [19:0]            r_t0;
    logic [19:0]            r_t3;
    logic [16:0]            r_q;
    logic signed [17:0]     r_w [4];
    logic [1:0]             r_k;
    logic signed [45:0]     r_acc;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;

    logic [15:0]            f;
    logic                   borrow;
    logic [AW+1:0]          d1, d1w, d2, d2w;
    logic [AW-1:0]          raddr_inc, wp_inc;
    logic signed [55:0]     p56, a56, c56, e56;
    logic signed [55:0]     p0, p1, p2, p3, p1r, p2r;
    logic signed [31:0]     a_v;
    logic signed [MA_W-1:0] c_v, e_v;
    logic [19:0]            t0_v, t3_v, t_sel, rem;
    logic [16:0]            q_v;
    logic signed [17:0]     qfix;
    logic signed [45:0]     acc_rnd;
    logic signed [29:0]     y_r;
    t_sample                y_v;
    logic signed [41:0]     fb_r;
    logic signed [25:0]     fb;
    t_sample                wr_v;

    ffd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign f      = 16'd0 - i_cfg.frac;
    assign borrow = |i_cfg.frac;

    // read position minus one, or minus two when the fraction is nonzero, wrapped into the store
    assign d1  = {2'b00, r_wp} - {2'b00, i_dint};
    assign d1w = d1[AW+1] ? d1 + DEPTH_X : d1;
    assign d2  = {2'b00, r_s1} - ((AW+2)'(borrow) + (AW+2)'(1));
    assign d2w = d2[AW+1] ? d2 + DEPTH_X : d2;

    assign raddr_inc = (r_raddr == LAST) ? '0 : r_raddr + AW'(1);
    assign wp_inc    = (r_wp == LAST) ? '0 : r_wp + AW'(1);

    // weight terms: a = F(F-U), c = F(F+U), e = (F+U)(F-U)
    assign p56 = $signed(mul_p[55:0]);
    assign a_v = $signed(mul_p[31:0]);
    assign c_v = MA_W'(a_v) + $signed({3'd0, f, 17'd0});
    assign e_v = MA_W'(a_v) + $signed({4'd0, f, 16'd0}) - $signed(36'h1_0000_0000);
    assign a56 = 56'(r_a);
    assign c56 = 56'(r_c);
    assign e56 = 56'(r_e);

    assign p0   = -(p56 + (a56 <<< 16));
    assign t0_v = p0[51:32] + 20'd3;
    assign p1   = p56 + (a56 <<< 17);
    assign p1r  = p1 + 56'sh1_0000_0000;
    assign p3   = p56 + (c56 <<< 17);
    assign t3_v = p3[51:32] + 20'd3;
    assign p2   = -(p56 + (e56 <<< 17));
    assign p2r  = p2 + 56'sh1_0000_0000;

    // divide by six: reciprocal estimate, then one correction step
    assign q_v   = mul_p[40:24];
    assign t_sel = (r_state == S_W6) ? r_t0 : r_t3;
    assign rem   = t_sel - 20'(r_q) * 20'd6;
    assign qfix  = $signed({1'b0, r_q}) + 18'(rem >= 20'd6);

    assign acc_rnd = r_acc + 46'sd32768;
    assign y_r     = $signed(acc_rnd[45:16]);
    assign y_v     = sat24(32'(y_r));

    assign fb_r = $signed(mul_p[41:0]) + 42'sd32768;
    assign fb   = $signed(fb_r[41:16]);
    assign wr_v = sat24(32'(r_x) + 32'(fb));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_ADDR: begin
                mul_a = $signed({20'd0, f}) - 36'sh10000;
                mul_b = $signed({9'd0, f});
            end
            S_W1: begin
                mul_a = MA_W'(a_v);
                mul_b = $signed({9'd0, f});
            end
            S_W2: begin
                mul_a = r_c;
                mul_b = $signed({9'd0, f});
            end
            S_W3: begin
                mul_a = r_e;
                mul_b = $signed({9'd0, f});
            end
            S_W4: begin
                mul_a = $signed({16'd0, r_t0});
                mul_b = $signed(RECIP6);
            end
            S_W5: begin
                mul_a = $signed({16'd0, r_t3});
                mul_b = $signed(RECIP6);
            end
            S_TAP: begin
                mul_a = r_rvalid ? MA_W'(r_rdata) : '0;
                mul_b = MB_W'(r_w[r_k]);
            end
            S_FB: begin
                mul_a = MA_W'(r_y);
                mul_b = $signed({8'd0, i_cfg.gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // entries are written in order from zero, so below r_wp or after a wrap is written
    always_ff @(posedge i_clk) begin
        if (r_state == S_WB) begin
            r_mem[r_wp] <= wr_v;
        end
        r_rdata  <= r_mem[r_raddr];
        r_rvalid <= r_full || (r_raddr < r_wp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_sample_in;
                        r_s1    <= d1w[AW-1:0];
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_raddr <= d2w[AW-1:0];
                    r_state <= S_W1;
                end
                S_W1: begin
                    r_a     <= a_v;
                    r_c     <= c_v;
                    r_e     <= e_v;
                    r_state <= S_W2;
                end
                S_W2: begin
                    r_t0    <= t0_v;
                    r_w[1]  <= $signed(p1r[50:33]);
                    r_state <= S_W3;
                end
                S_W3: begin
                    r_t3    <= t3_v;
                    r_state <= S_W4;
                end
                S_W4: begin
                    r_w[2]  <= $signed(p2r[50:33]);
                    r_state <= S_W5;
                end
                S_W5: begin
                    r_q     <= q_v;
                    r_state <= S_W6;
                end
                S_W6: begin
                    r_w[0]  <= qfix;
                    r_q     <= q_v;
                    r_state <= S_W7;
                end
                S_W7: begin
                    r_w[3]  <= qfix;
                    r_raddr <= raddr_inc;
                    r_acc   <= '0;
                    r_k     <= '0;
                    r_state <= S_TAP;
                end
                S_TAP: begin
                    r_raddr <= raddr_inc;
                    if (r_k != 2'd0) begin
                        r_acc <= r_acc + 46'(mul_p);
                    end
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc   <= r_acc + 46'(mul_p);
                    r_state <= S_Y;
                end
                S_Y: begin
                    r_y     <= y_v;
                    r_state <= S_FB;
                end
                S_FB: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_wp <= wp_inc;
                    if (r_wp == LAST) begin
                        r_full <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_y;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("transaction accepted while busy");

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= LAST)
        else $error("write pointer out of range");

    a_raddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> (r_raddr <= LAST))
        else $error("read address out of range");

    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_full))
        else $error("fill flag dropped");

    a_weight_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> (!r_w[0][17] && !r_w[2][17] && !r_w[3][17]))
        else $error("weight sign wrong");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not posted");

endmodule

>>> sv/fractional_feedback_delay.sv
// Top level: register port, delay reduction and handshake of the feedback delay.
//
//  channel  | signals                                         | dir
//  ---------+-------------------------------------------------+-----
//  input    | i_in_valid, o_in_ready, i_sample_in             | in
//  output   | o_out_valid, i_out_ready, o_sample_out          | out
//  config   | psel, penable, pwrite, paddr, pwdata, prdata    | in
//
// A new sample is accepted only after the previous one returns the core to idle; the
// shared multiplier is used eleven times per sample and the store read port once a tap.
// A write to delay_time holds o_in_ready low while the integer delay
// is reduced modulo the store depth by a reciprocal multiply and a subtract.
// Reset clears control only; unwritten store entries read as zero via the fill flag.
// A result waiting in the output register stalls the core only at its last step.
module fractional_feedback_delay import ffd_pkg::*; #(
    parameter int BUFFER_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_sample     i_sample_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_sample     o_sample_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int RW = (AW > 16) ? AW : 16;

    localparam logic REG_DELAY = 1'b0;
    localparam logic REG_GAIN  = 1'b1;
    // ceil(2^32 / depth): exact quotient for any 16-bit integer delay
    localparam logic [31:0] RECIP_D =
        32'(((64'd1 << 32) + 64'(BUFFER_DEPTH) - 64'd1) / 64'(BUFFER_DEPTH));

    logic [31:0]       r_delay;
    logic [GAIN_W-1:0] r_gain;
    logic [15:0]       r_rem;
    logic [15:0]       r_quo;
    logic              r_red_busy;
    logic              r_red_k;

    logic              wr_en;
    logic [GAIN_W-1:0] gain_clamp;
    logic [47:0]       quo_p;
    logic [31:0]       quo_d;
    logic [RW-1:0]     rem_w;
    logic [AW-1:0]     dint;
    logic              core_idle;
    logic              start;
    t_cfg              cfg;

    assign pready     = 1'b1;
    assign wr_en      = psel & penable & pwrite & pready;
    assign gain_clamp = (pwdata[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE : pwdata[GAIN_W-1:0];

    assign quo_p = 48'(r_rem) * 48'(RECIP_D);
    assign quo_d = {16'd0, r_quo} * 32'(BUFFER_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay    <= '0;
            r_gain     <= '0;
            r_rem      <= '0;
            r_quo      <= '0;
            r_red_busy <= 1'b0;
            r_red_k    <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_DELAY: begin
                    r_delay    <= pwdata;
                    r_rem      <= pwdata[31:16];
                    r_red_busy <= 1'b1;
                    r_red_k    <= 1'b0;
                end
                REG_GAIN: r_gain <= gain_clamp;
            endcase
        end else if (r_red_busy) begin
            if (!r_red_k) begin
                r_quo   <= quo_p[47:32];
                r_red_k <= 1'b1;
            end else begin
                r_rem      <= r_rem - quo_d[15:0];
                r_red_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DELAY: prdata = r_delay;
            REG_GAIN:  prdata = {15'd0, r_gain};
        endcase
    end

    assign rem_w      = RW'(r_rem);
    assign dint       = rem_w[AW-1:0];
    assign cfg        = {r_delay[15:0], r_gain};
    assign o_in_ready = core_idle & ~r_red_busy;
    assign start      = i_in_valid & o_in_ready;

    ffd_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_sample_in  (i_sample_in),
        .i_dint       (dint),
        .i_cfg        (cfg),
        .o_idle       (core_idle),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out)
    );

endmodule
